// ===== src/fixed_point_to_decimal_ascii_top_assert.svh =====
// Assertion macros for the fixed-point to decimal ASCII converter.
// Included by the top level; needs nothing else.
`ifndef FIXED_POINT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define FIXED_POINT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPDA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPDA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fpda_pkg.sv =====
// Shared constants, types and helper functions for the decimal ASCII converter.
// No dependencies.
package fpda_pkg;

    localparam int INT_BITS_DEF        = 32;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Register index decoded from paddr[2].
    localparam logic REG_FRAC_DIGITS = 1'b0;

    typedef struct packed {
        logic load;
        logic shift;
    } bcd_cmd_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } bcd_stat_t;

    typedef struct packed {
        logic load;
        logic step;
    } frac_cmd_t;

    typedef struct packed {
        logic       is_zero;
        logic       next_zero;
        logic [3:0] digit;
    } frac_stat_t;

    // Decimal digits needed for an unsigned value of the given bit count;
    // 1233/4096 is a close lower bound of log10(2).
    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

// ===== src/fpda_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three), with a digit
// shifter for reading the result out most significant digit first. Uses fpda_pkg.
module fpda_bcd #(
    parameter int INT_BITS = fpda_pkg::INT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpda_pkg::bcd_cmd_t  cmd,
    input  logic [INT_BITS-1:0] ipart,
    output fpda_pkg::bcd_stat_t stat
);
    import fpda_pkg::*;

    localparam int NDIG = dec_digits(INT_BITS);
    localparam int BW   = NDIG * 4;
    localparam int CW   = $clog2(INT_BITS + 1);

    logic [INT_BITS-1:0] bin_reg, bin_next;
    logic [BW-1:0]       bcd_reg, bcd_next, adj;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    // Each digit that would overflow on doubling is corrected first.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.load) begin
            bin_next  = ipart;
            bcd_next  = '0;
            cnt_next  = CW'(INT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[BW-2:0], bin_reg[INT_BITS-1]};
            bin_next = {bin_reg[INT_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end else if (cmd.shift) begin
            bcd_next = {bcd_reg[BW-5:0], 4'b0000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.top_digit = bcd_reg[BW-1 -: 4];

endmodule

// ===== src/fpda_frac.sv =====
// Fraction digit generator: multiplies the remaining fraction by ten once per
// digit and yields the integer carry as the next decimal digit. Uses fpda_pkg.
module fpda_frac #(
    parameter int FRAC_BITS = fpda_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  fpda_pkg::frac_cmd_t  cmd,
    input  logic [FRAC_BITS-1:0] frac,
    output fpda_pkg::frac_stat_t stat
);
    import fpda_pkg::*;

    localparam int PW = FRAC_BITS + 4;

    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [PW-1:0]        prod;

    // Times ten as eight times plus two times.
    assign prod = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};

    always_comb begin
        frac_next = frac_reg;
        if (cmd.load) begin
            frac_next = frac;
        end else if (cmd.step) begin
            frac_next = prod[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg <= frac_next;
    end

    assign stat.is_zero   = (frac_reg == '0);
    assign stat.next_zero = (prod[FRAC_BITS-1:0] == '0);
    assign stat.digit     = prod[PW-1:FRAC_BITS];

endmodule

// ===== src/fixed_point_to_decimal_ascii_top.sv =====
// Fixed-point to decimal ASCII converter, top level: configuration port,
// sequencer and output register. Uses fpda_pkg, fpda_bcd, fpda_frac and the
// assertion header.
//
// Usage: each item on the s_ stream is one signed fixed-point number with
// INT_BITS integer and FRAC_BITS fraction bits. The m_ stream returns its
// decimal text one ASCII character per item: an optional minus sign, the
// integer digits (at least one), and when frac_digits is nonzero a dot and
// up to frac_digits fraction digits, stopping early once the fraction is
// zero. m_tlast marks the final character of each number.
// Timing: the integer part is converted one bit per cycle. Then a minus sign
// enters the output register if the input is negative, leading zero digits
// are skipped, and the digits follow, most significant first. After that one
// character leaves per cycle while m_tready keeps the output register free.
// A new input is taken the cycle after the final character enters the output
// register. A stalled m_tready holds the character in the output register
// and pauses the sequencer at its next character. Reset clears frac_digits
// to zero and empties the block; s_tready stays low while reset is held.
module fixed_point_to_decimal_ascii_top #(
    parameter int INT_BITS        = fpda_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = fpda_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = fpda_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // value, from bit 0 up, zero padded to whole bytes
    input  logic [((INT_BITS + FRAC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_out
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpda_pkg::*;

    localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
    localparam int NDIG       = dec_digits(INT_BITS);
    localparam int DCW        = $clog2(NDIG + 1);
    localparam int NDW        = $clog2(MAX_FRAC_DIGITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_INT  = 3'd4;
    localparam logic [2:0] ST_DOT  = 3'd5;
    localparam logic [2:0] ST_FRAC = 3'd6;

    // Configuration register.
    logic [3:0] frac_digits_reg, frac_digits_next;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        frac_digits_next = frac_digits_reg;
        if (cfg_write && (paddr[2] == REG_FRAC_DIGITS)) begin
            frac_digits_next = pwdata[3:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_FRAC_DIGITS) begin
            prdata = {28'b0, frac_digits_reg};
        end else begin
            prdata = '0;
        end
    end

    logic [NDW-1:0] nd_sat;

    always_comb begin
        if (5'(frac_digits_reg) > 5'(MAX_FRAC_DIGITS)) begin
            nd_sat = NDW'(MAX_FRAC_DIGITS);
        end else begin
            nd_sat = NDW'(frac_digits_reg);
        end
    end

    // Input magnitude split into integer and fraction parts.
    logic [TOTAL_BITS-1:0] raw, mag;
    logic                  raw_neg;

    assign raw     = s_tdata[TOTAL_BITS-1:0];
    assign raw_neg = raw[TOTAL_BITS-1];
    assign mag     = raw_neg ? (~raw + TOTAL_BITS'(1)) : raw;

    bcd_cmd_t   bcd_cmd;
    bcd_stat_t  bcd_stat;
    frac_cmd_t  frac_cmd;
    frac_stat_t frac_stat;

    fpda_bcd #(
        .INT_BITS (INT_BITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bcd_cmd),
        .ipart   (mag[TOTAL_BITS-1:FRAC_BITS]),
        .stat    (bcd_stat)
    );

    fpda_frac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac (
        .aclk (aclk),
        .cmd  (frac_cmd),
        .frac (mag[FRAC_BITS-1:0]),
        .stat (frac_stat)
    );

    // Sequencer.
    logic [2:0]     state_reg, state_next;
    logic           neg_reg, neg_next;
    logic [DCW-1:0] dig_cnt_reg, dig_cnt_next;
    logic [NDW-1:0] fd_cnt_reg, fd_cnt_next;
    logic           can_emit, emit, emit_last;
    logic [7:0]     emit_char;

    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_char_reg, m_char_next;
    logic           m_last_reg, m_last_next;

    assign can_emit = !m_valid_reg || m_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        dig_cnt_next  = dig_cnt_reg;
        fd_cnt_next   = fd_cnt_reg;
        bcd_cmd       = '0;
        frac_cmd      = '0;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_char     = CH_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    bcd_cmd.load  = 1'b1;
                    frac_cmd.load = 1'b1;
                    neg_next      = raw_neg;
                    dig_cnt_next  = DCW'(NDIG);
                    fd_cnt_next   = nd_sat;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!bcd_stat.busy) begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits but keep at least one.
                if ((bcd_stat.top_digit == 4'd0) && (dig_cnt_reg > DCW'(1))) begin
                    bcd_cmd.shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - DCW'(1);
                end else begin
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    emit_char     = CH_ZERO + {4'b0000, bcd_stat.top_digit};
                    bcd_cmd.shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - DCW'(1);
                    if (dig_cnt_reg == DCW'(1)) begin
                        emit_last  = (fd_cnt_reg == '0);
                        state_next = emit_last ? ST_IDLE : ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_char  = CH_DOT;
                    emit_last  = frac_stat.is_zero;
                    state_next = frac_stat.is_zero ? ST_IDLE : ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    emit_char     = CH_ZERO + {4'b0000, frac_stat.digit};
                    frac_cmd.step = 1'b1;
                    fd_cnt_next   = fd_cnt_reg - NDW'(1);
                    emit_last     = (fd_cnt_reg == NDW'(1)) || frac_stat.next_zero;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_char_next  = emit_char;
            m_last_next  = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_digits_reg <= 4'd0;
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
        end else begin
            frac_digits_reg <= frac_digits_next;
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg     <= neg_next;
        dig_cnt_reg <= dig_cnt_next;
        fd_cnt_reg  <= fd_cnt_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

`include "fixed_point_to_decimal_ascii_top_assert.svh"

    `FPDA_ASSERT_NEXT(a_conv_starts, aclk, aresetn,
        s_tvalid && s_tready, bcd_stat.busy,
        "conversion did not start after an input item")
    `FPDA_ASSERT_IMPLY(a_sign_only_neg, aclk, aresetn,
        emit && (emit_char == CH_MINUS), neg_reg,
        "minus sign for a non-negative number")
    `FPDA_ASSERT_IMPLY(a_frac_budget, aclk, aresetn,
        emit && (state_reg == ST_FRAC), fd_cnt_reg != '0,
        "fraction digit beyond the configured count")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the fixed-point to decimal ASCII converter.
// Drives fixed-point numbers and frac_digits settings, and checks every character against
// a predictor in the scoreboard. Depends on fpda_pkg and fixed_point_to_decimal_ascii_top.
module testbench;
    import fpda_pkg::*;

    localparam int VALUE_BITS = INT_BITS_DEF + FRAC_BITS_DEF;
    localparam logic [2:0] ADDR_FRAC_DIGITS = {REG_FRAC_DIGITS, 2'b00};
    localparam logic [7:0] RADIX = 8'd10;

    typedef logic [VALUE_BITS-1:0] fixed_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    // Predicts the decimal text of each accepted number and checks the characters in order.
    class ascii_scoreboard;
        ascii_char_t expected_chars[$];
        logic [3:0]  frac_digits;
        int          mismatches;

        function new();
            frac_digits = 4'd0;
            mismatches  = 0;
        endfunction

        function void note_number(input fixed_t value);
            fixed_t                     mag;
            logic [INT_BITS_DEF-1:0]    ipart;
            logic [FRAC_BITS_DEF-1:0]   frac;
            logic [FRAC_BITS_DEF+3:0]   prod;
            logic [7:0]                 text[$];
            int                         limit;
            int                         n;
            ascii_char_t                item;
            mag   = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            ipart = mag[VALUE_BITS-1:FRAC_BITS_DEF];
            frac  = mag[FRAC_BITS_DEF-1:0];
            limit = (frac_digits > MAX_FRAC_DIGITS_DEF) ? MAX_FRAC_DIGITS_DEF : frac_digits;
            // Integer digits are collected least significant first, so they go in at the front.
            do begin
                text.push_front(CH_ZERO + 8'(ipart % RADIX));
                ipart = ipart / RADIX;
            end while (ipart != 0);
            if (value[VALUE_BITS-1])
                text.push_front(CH_MINUS);
            if (limit != 0) begin
                text.push_back(CH_DOT);
                n = 0;
                while (frac != 0 && n < limit) begin
                    prod = {4'b0, frac} * RADIX;
                    text.push_back(CH_ZERO + 8'(prod[FRAC_BITS_DEF+3:FRAC_BITS_DEF]));
                    frac = prod[FRAC_BITS_DEF-1:0];
                    n++;
                end
            end
            foreach (text[i]) begin
                item.ch   = text[i];
                item.last = (i == text.size() - 1);
                expected_chars.push_back(item);
            end
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_char(input logic [7:0] ch, input logic last_flag);
            ascii_char_t want;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("char 0x%02h with nothing expected", ch));
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("char 0x%02h, expected 0x%02h", ch, want.ch));
            if (last_flag !== want.last)
                report_mismatch($sformatf("last %b on char 0x%02h, expected %b",
                                          last_flag, ch, want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // value
    logic [VALUE_BITS-1:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // char_out
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    ascii_scoreboard sb = new();
    ready_mode_t     ready_mode = READY_ALWAYS;
    int              hold_cycles = 0;

    fixed_point_to_decimal_ascii_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Character receiver: checks each accepted item, then picks the next tready.
    initial begin
        int tick;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            tick++;
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                case (ready_mode)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                    READY_PATTERN: m_tready <= ((tick % 7) < 4);
                    default:       m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // All tasks below start and end in the time step of a rising edge.
    task automatic send_number(input fixed_t value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_number(value);
    endtask

    task automatic wait_drain();
        while (sb.expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_frac_digits(input logic [3:0] digits);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FRAC_DIGITS;
        // The bits above the register are filled with noise; the block must ignore them.
        pwdata  <= {28'($urandom()), digits};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.frac_digits = digits;
    endtask

    function automatic fixed_t signed_of(input fixed_t mag, input logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    function automatic fixed_t random_value();
        fixed_t     v;
        logic [63:0] p;
        int         k;
        case ($urandom_range(0, 9))
            0, 1, 2: v = fixed_t'({$urandom(), $urandom()});
            3, 4:    v = signed_of({32'($urandom_range(0, 999)),
                                    16'($urandom())}, 1'($urandom_range(0, 1)));
            // Fractions with set bits only in the top four places end within four digits.
            5:       v = signed_of({32'($urandom_range(0, 99)),
                                    16'($urandom_range(0, 15)) << 12},
                                   1'($urandom_range(0, 1)));
            6: begin
                p = 64'd1;
                k = $urandom_range(1, 10);
                repeat (k) p = p * 10;
                p = p - $urandom_range(0, 1);
                if (p > 64'hFFFF_FFFF)
                    p = 64'hFFFF_FFFF;
                v = signed_of({p[31:0], 16'($urandom())}, 1'($urandom_range(0, 1)));
            end
            7: begin
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    3: v = fixed_t'(1);
                    4: v = '1;
                    5: v = fixed_t'(65536);
                    6: v = signed_of(fixed_t'(65536), 1'b1);
                    default: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
                endcase
            end
            default: v = signed_of({32'($urandom()),
                                    16'($urandom_range(0, 3))}, 1'($urandom_range(0, 1)));
        endcase
        return v;
    endfunction

    task automatic send_random_numbers(input int count, input bit drain_midway);
        int burst;
        int gap;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 10);
            while (burst > 0 && sent < count) begin
                send_number(random_value());
                burst--;
                sent++;
                if (drain_midway && sent == count / 2) begin
                    s_tvalid <= 1'b0;
                    wait_drain();
                    @(posedge aclk);
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [3:0] settings[12];
        settings = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd9, 4'd2, 4'd7, 4'd4, 4'd6, 4'd12};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: no point, so only the sign and the integer part appear.
        ready_mode = READY_ALWAYS;
        send_number('0);
        send_number(fixed_t'(65536));
        send_number(signed_of(fixed_t'(65536), 1'b1));
        send_number({1'b0, {(VALUE_BITS-1){1'b1}}});
        send_number({1'b1, {(VALUE_BITS-1){1'b0}}});
        send_number(signed_of(fixed_t'(32768), 1'b1));
        s_tvalid <= 1'b0;

        set_frac_digits(4'd8);
        ready_mode = READY_RANDOM;
        send_number('0);
        send_number(fixed_t'(32768));
        send_number(signed_of(fixed_t'(32768), 1'b1));
        send_number(fixed_t'(1));
        send_number('1);
        send_number(fixed_t'(16'hFFFF));
        send_number({1'b0, {(VALUE_BITS-1){1'b1}}});
        send_number({1'b1, {(VALUE_BITS-1){1'b0}}});
        send_number({32'd3, 16'h4000});
        send_number({32'd123456, 16'h1000});
        send_number({32'hFFFF_FFFF, 16'h8000});
        s_tvalid <= 1'b0;

        // Settings above the digit limit saturate.
        set_frac_digits(4'd15);
        send_number('1);
        send_number(signed_of({32'd42, 16'h0001}, 1'b1));
        s_tvalid <= 1'b0;

        set_frac_digits(4'd1);
        send_number({32'd7, 16'h0CCD});
        send_number(fixed_t'(16'h1000));
        s_tvalid <= 1'b0;

        foreach (settings[i]) begin
            set_frac_digits(settings[i]);
            ready_mode = ready_mode_t'(i % 4);
            // Long receiver hold-off so the block backs up into its input.
            if (i == 2)
                hold_cycles = 400;
            send_random_numbers(23, i == 5);
        end

        wait_drain();
        repeat (200) @(posedge aclk);
        if (sb.expected_chars.size() != 0)
            sb.report_mismatch($sformatf("%0d characters never arrived",
                                         sb.expected_chars.size()));
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
